/* design/bisection_square_root_macros.svh */
// Assertion macros shared by the bisection square root block.
`ifndef BISECTION_SQUARE_ROOT_MACROS_SVH
`define BISECTION_SQUARE_ROOT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bsr_pkg.sv */
`default_nettype none

package bsr_pkg;

  // Number format of the radicand and the root.
  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 16;
  localparam int ROOT_W     = INT_BITS + FRAC_BITS;
  // Exact square and radicand aligned to 2*FRAC_BITS fraction bits.
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int TGT_W      = ROOT_W + FRAC_BITS;

  // Port widths fixed by the field definitions.
  localparam int DATA_W     = 32;
  localparam int TOL_W      = 32;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(4295);
  localparam logic [STEP_W-1:0] LIMIT_RESET = STEP_W'(100);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic square;
    logic step;
  } bsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tol_met;
    logic positive;
  } bsr_status_t;

endpackage

`default_nettype wire

/* design/bsr_datapath.sv */
`default_nettype none

module bsr_datapath (
  input  wire logic                          clk,
  input  wire bsr_pkg::bsr_cmd_t             cmd,
  input  wire logic [bsr_pkg::DATA_W-1:0]    radicand,
  input  wire logic [bsr_pkg::TOL_W-1:0]     tolerance,
  output bsr_pkg::bsr_status_t               status,
  output logic [bsr_pkg::ROOT_W-1:0]         root
);

  localparam logic [bsr_pkg::ROOT_W-1:0] ONE = bsr_pkg::ROOT_W'(1) << bsr_pkg::FRAC_BITS;

  logic [bsr_pkg::ROOT_W-1:0] low_r, low_nxt;
  logic [bsr_pkg::ROOT_W-1:0] high_r, high_nxt;
  logic [bsr_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [bsr_pkg::ROOT_W-1:0] mid_lo_r, mid_lo_nxt;
  logic [bsr_pkg::ROOT_W-1:0] mid_hi_r, mid_hi_nxt;
  logic [bsr_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [bsr_pkg::TGT_W-1:0]  target_r, target_nxt;

  logic [bsr_pkg::ROOT_W-1:0] n;
  logic [bsr_pkg::ROOT_W-1:0] init_low;
  logic [bsr_pkg::ROOT_W-1:0] init_high;
  logic [bsr_pkg::ROOT_W:0]   init_sum;
  logic [bsr_pkg::ROOT_W:0]   lo_sum;
  logic [bsr_pkg::ROOT_W:0]   hi_sum;
  logic [bsr_pkg::SQ_W-1:0]   target_ext;
  logic [bsr_pkg::SQ_W-1:0]   diff_pos;
  logic [bsr_pkg::SQ_W-1:0]   diff_neg;
  logic [bsr_pkg::SQ_W-1:0]   magnitude;
  logic                       positive;

  // Initial bracket: min(1, n) and max(1, n), with the floored midpoint.
  assign n         = radicand[bsr_pkg::ROOT_W-1:0];
  assign init_low  = (n < ONE) ? n : ONE;
  assign init_high = (n > ONE) ? n : ONE;
  assign init_sum  = {1'b0, init_low} + {1'b0, init_high};

  // Both candidate midpoints are prepared while the square is formed.
  assign lo_sum = {1'b0, low_r} + {1'b0, root_r};
  assign hi_sum = {1'b0, root_r} + {1'b0, high_r};

  // Error of the current guess against n at 2*FRAC_BITS fraction bits.
  assign target_ext = bsr_pkg::SQ_W'(target_r);
  assign diff_pos   = sq_r - target_ext;
  assign diff_neg   = target_ext - sq_r;
  assign positive   = sq_r > target_ext;
  assign magnitude  = positive ? diff_pos : diff_neg;

  assign status.positive = positive;
  assign status.tol_met  = magnitude <= bsr_pkg::SQ_W'(tolerance);
  assign root            = root_r;

  // Next values of the search registers.
  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    root_nxt   = root_r;
    mid_lo_nxt = mid_lo_r;
    mid_hi_nxt = mid_hi_r;
    sq_nxt     = sq_r;
    target_nxt = target_r;
    if (cmd.load) begin
      low_nxt    = init_low;
      high_nxt   = init_high;
      root_nxt   = init_sum[bsr_pkg::ROOT_W:1];
      target_nxt = {n, bsr_pkg::FRAC_BITS'(0)};
    end else if (cmd.square) begin
      sq_nxt     = bsr_pkg::SQ_W'(root_r) * bsr_pkg::SQ_W'(root_r);
      mid_lo_nxt = lo_sum[bsr_pkg::ROOT_W:1];
      mid_hi_nxt = hi_sum[bsr_pkg::ROOT_W:1];
    end else if (cmd.step) begin
      if (positive) begin
        high_nxt = root_r;
        root_nxt = mid_lo_r;
      end else begin
        low_nxt  = root_r;
        root_nxt = mid_hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r    <= low_nxt;
    high_r   <= high_nxt;
    root_r   <= root_nxt;
    mid_lo_r <= mid_lo_nxt;
    mid_hi_r <= mid_hi_nxt;
    sq_r     <= sq_nxt;
    target_r <= target_nxt;
  end

endmodule

`default_nettype wire

/* design/bsr_ctrl.sv */
`default_nettype none

module bsr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bsr_pkg::STEP_W-1:0]    iteration_limit,
  input  wire bsr_pkg::bsr_status_t          status,
  output bsr_pkg::bsr_cmd_t                  cmd,
  output logic                               busy,
  output logic                               out_valid,
  output logic [bsr_pkg::STEP_W-1:0]         out_steps_used,
  output logic                               out_converged
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SQUARE = 2'd1;
  localparam logic [1:0] S_EVAL   = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [bsr_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic                        valid_r, valid_nxt;
  logic [bsr_pkg::STEP_W-1:0]  res_steps_r, res_steps_nxt;
  logic                        res_conv_r, res_conv_nxt;
  logic                        finish;

  // The search ends on a met tolerance or on the step limit.
  assign finish = status.tol_met || (steps_r == iteration_limit);

  // Sequencer: load, then alternate squaring and evaluation.
  always_comb begin
    state_nxt     = state_r;
    steps_nxt     = steps_r;
    valid_nxt     = 1'b0;
    res_steps_nxt = res_steps_r;
    res_conv_nxt  = res_conv_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          steps_nxt = '0;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        if (finish) begin
          valid_nxt     = 1'b1;
          res_steps_nxt = steps_r;
          res_conv_nxt  = status.tol_met;
          state_nxt     = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    steps_r     <= steps_nxt;
    res_steps_r <= res_steps_nxt;
    res_conv_r  <= res_conv_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = valid_r;
  assign out_steps_used = res_steps_r;
  assign out_converged  = res_conv_r;

endmodule

`default_nettype wire

/* design/bisection_square_root.sv */
// Bisection square root of an unsigned Q16.16 value. A transaction is taken
// when start is high while busy is low; busy then stays high until the result
// is produced. Each bisection step is a squaring in the 32x32 multiplier
// followed by an error compare and bound update, and a new transaction can
// start in the cycle the result is shown. The result appears on out_root,
// out_steps_used and out_converged for exactly one cycle with out_valid
// high; the receiver cannot stall it, so it must take it then.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none
`include "bisection_square_root_macros.svh"

module bisection_square_root (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bsr_pkg::DATA_W-1:0]      in_radicand,
  output logic                                 out_valid,
  output logic [bsr_pkg::DATA_W-1:0]           out_root,
  output logic [bsr_pkg::STEP_W-1:0]           out_steps_used,
  output logic                                 out_converged,
  input  wire logic                            cfg_we,
  input  wire logic [bsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsr_pkg::TOL_W-1:0]       cfg_wdata
);

  logic [bsr_pkg::TOL_W-1:0]  tolerance_r;
  logic [bsr_pkg::STEP_W-1:0] limit_r;
  bsr_pkg::bsr_cmd_t          cmd;
  bsr_pkg::bsr_status_t       status;
  logic [bsr_pkg::ROOT_W-1:0] root;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= bsr_pkg::TOL_RESET;
      limit_r     <= bsr_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsr_pkg::REG_TOLERANCE:  tolerance_r <= cfg_wdata;
        bsr_pkg::REG_ITER_LIMIT: limit_r     <= cfg_wdata[bsr_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bsr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .iteration_limit (limit_r),
    .status          (status),
    .cmd             (cmd),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_steps_used  (out_steps_used),
    .out_converged   (out_converged)
  );

  bsr_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .radicand  (in_radicand),
    .tolerance (tolerance_r),
    .status    (status),
    .root      (root)
  );

  assign out_root = bsr_pkg::DATA_W'(root);

  // A result is only shown once the sequencer has returned to idle.
  `BSR_ASSERT_NOW(a_valid_idle, out_valid, !busy, "result shown while busy")

  // An accepted transaction makes the block busy in the next cycle.
  `BSR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted start did not raise busy")

  // The step count never exceeds the configured limit.
  `BSR_ASSERT_NOW(a_steps_limit, out_valid, out_steps_used <= limit_r,
                  "steps used exceed the iteration limit")

  // A non-converged result only comes from running out of steps.
  `BSR_ASSERT_NOW(a_noconv_limit, out_valid && !out_converged, out_steps_used == limit_r,
                  "non-converged result before the iteration limit")

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  import bsr_pkg::*;

  // Fixed-point one, the pivot between the two bracketing modes.
  localparam logic [DATA_W-1:0] UNITY = DATA_W'(1) << FRAC_BITS;
  // Longest run with no transaction: a full 255-step search plus the longest gap.
  localparam int STALL_LIMIT = 4000;
  // Idle cycles let pass before a register write and at the end of the run.
  localparam int SETTLE_CYCLES = 8;

  // Edge values of the radicand, exact squares and values around one.
  localparam logic [DATA_W-1:0] CORNER_RADICANDS [18] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_4000,
    32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0004_0000,
    32'h0009_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'hFFFE_0001,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic [STEP_W-1:0] steps_used;
    logic              converged;
  } root_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [DATA_W-1:0] in_radicand = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_root;
  logic [STEP_W-1:0] out_steps_used;
  logic              out_converged;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOLERANCE;
  logic [TOL_W-1:0]  cfg_wdata = '0;

  // Register copies used for prediction; updated only while the block is idle.
  logic [TOL_W-1:0]  tol_setting = TOL_RESET;
  logic [STEP_W-1:0] limit_setting = LIMIT_RESET;

  logic [DATA_W-1:0] pending_radicands [$];
  root_result_t      expected_roots [$];
  bit                steady_sender = 1'b0;
  int                gap_left = 0;
  int                mismatch_count = 0;
  int                accepted_count = 0;
  int                converged_count = 0;
  int                setting_count = 0;
  int                idle_cycles = 0;

  bisection_square_root dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_radicand    (in_radicand),
    .out_valid      (out_valid),
    .out_root       (out_root),
    .out_steps_used (out_steps_used),
    .out_converged  (out_converged),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bisection search between min(1,n) and max(1,n), with the exact error in Q32.32.
  function automatic root_result_t bisect_root(logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] lower, upper, guess;
    logic [DATA_W:0]   bound_sum;
    logic [63:0]       square, target, error_mag;
    logic              above;
    int unsigned       steps;
    root_result_t      res;
    lower = (n < UNITY) ? n : UNITY;
    upper = (n > UNITY) ? n : UNITY;
    bound_sum = {1'b0, lower} + {1'b0, upper};
    guess = bound_sum[DATA_W:1];
    target = 64'(n) << FRAC_BITS;
    steps = 0;
    while (1'b1) begin
      square = 64'(guess) * 64'(guess);
      above = square > target;
      error_mag = above ? square - target : target - square;
      res.converged = error_mag <= 64'(tol_setting);
      if (res.converged || steps >= limit_setting) break;
      if (above) begin
        upper = guess;
      end else begin
        lower = guess;
      end
      bound_sum = {1'b0, lower} + {1'b0, upper};
      guess = bound_sum[DATA_W:1];
      steps++;
    end
    res.root = guess;
    res.steps_used = STEP_W'(steps);
    return res;
  endfunction

  // Mostly short pauses, now and then one long enough to span a whole search; none when steady.
  function automatic int draw_gap();
    int pick;
    if (steady_sender) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 300);
  endfunction

  // Radicands spread over full range, fractions, values near one and exact squares.
  function automatic logic [DATA_W-1:0] draw_radicand();
    logic [15:0] base;
    base = 16'($urandom);
    case ($urandom_range(0, 7))
      0: return $urandom >> $urandom_range(0, 31);
      1: return $urandom_range(0, UNITY);
      2: return UNITY + $urandom_range(0, 64) - 32;
      3: return 32'(base) * 32'(base);
      4: return (32'(base[7:0]) * 32'(base[7:0])) << FRAC_BITS;
      5: return CORNER_RADICANDS[$urandom_range(0, 17)];
      default: return $urandom;
    endcase
  endfunction

  // Driver: holds each transaction until the block takes it, then maybe pauses.
  always @(posedge clk) begin : drive_radicands
    bit took;
    took = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (took) begin
        expected_roots.push_back(bisect_root(in_radicand));
        void'(pending_radicands.pop_front());
        accepted_count++;
        gap_left = draw_gap();
      end
      if (start && !took) begin
        // Still waiting for the block to take the current transaction.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        in_radicand <= $urandom;
      end else if (pending_radicands.size() > 0) begin
        start <= 1'b1;
        in_radicand <= pending_radicands[0];
      end else begin
        start <= 1'b0;
        in_radicand <= $urandom;
      end
    end
  end

  // Monitor: every strobed result must match the oldest outstanding prediction.
  always @(posedge clk) begin : check_roots
    root_result_t want;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $error("result strobed with no transaction outstanding: root %h", out_root);
        mismatch_count++;
      end else begin
        want = expected_roots.pop_front();
        if (out_converged) converged_count++;
        if (out_root !== want.root) begin
          $error("root: expected %h, actual %h", want.root, out_root);
          mismatch_count++;
        end
        if (out_steps_used !== want.steps_used) begin
          $error("steps_used: expected %0d, actual %0d", want.steps_used, out_steps_used);
          mismatch_count++;
        end
        if (out_converged !== want.converged) begin
          $error("converged: expected %b, actual %b", want.converged, out_converged);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles.", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Waits until every queued transaction is taken and every result has come.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_radicands.size() != 0 || expected_roots.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_wdata <= $urandom;
    if (idx == REG_TOLERANCE) begin
      tol_setting = value;
    end else begin
      limit_setting = value[STEP_W-1:0];
    end
  endtask

  // Both registers per setting; the limit write carries junk in the unused upper bits.
  task automatic apply_setting(input logic [TOL_W-1:0] tol, input logic [STEP_W-1:0] limit);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_ITER_LIMIT, {24'($urandom), limit});
    setting_count++;
  endtask

  task automatic run_random(input int count, input bit steady);
    steady_sender = steady;
    @(negedge clk);
    repeat (count) pending_radicands.push_back(draw_radicand());
    wait_drained();
  endtask

  // Stimulus: corners and a random run at reset values, then a series of register settings.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    foreach (CORNER_RADICANDS[i]) pending_radicands.push_back(CORNER_RADICANDS[i]);
    wait_drained();
    run_random(200, 1'b0);

    // Zero tolerance: only exact hits converge, everything else runs to the limit.
    apply_setting('0, 8'd255);
    run_random(60, 1'b0);
    // Widest tolerance with a single step allowed.
    apply_setting('1, 8'd1);
    run_random(120, 1'b1);
    // A zero limit returns the first guess untouched.
    apply_setting('0, 8'd0);
    run_random(25, 1'b0);
    apply_setting(TOL_W'(65536), 8'd40);
    run_random(150, 1'b1);
    repeat (3) begin
      apply_setting($urandom >> $urandom_range(0, 31), STEP_W'($urandom_range(1, 255)));
      run_random(120, 1'b0);
    end
    apply_setting(TOL_W'(1), 8'd30);
    run_random(100, 1'b0);
    apply_setting(TOL_RESET, LIMIT_RESET);
    run_random(100, 1'b0);

    $display("Checked %0d square roots over %0d register settings plus reset values.",
             accepted_count, setting_count);
    $display("%0d met the tolerance, %0d stopped at the step limit.",
             converged_count, accepted_count - converged_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/bsr_pkg.sv
design/bsr_datapath.sv
design/bsr_ctrl.sv
design/bisection_square_root.sv
test/testbench.sv
